// ----- design/obf_pkg.sv -----
// ----------------------------------------------------------------------------
// obf_pkg - oriented box fit shared definitions
// Field widths, register indexes and tracker limits for the box fitter.
// ----------------------------------------------------------------------------
package obf_pkg;

  localparam int PointW = 20;
  localparam int TrkW   = 21;
  localparam int ExtW   = 23;
  localparam int SumW   = 24;
  localparam int OutW   = 20;
  localparam int CoefW  = 16;
  localparam int MinW   = 14;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_HEADING_COS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HEADING_SIN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_WIDTH   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_LENGTH  = 2'd3;

  localparam logic signed [TrkW-1:0] TRK_MAX = 21'sd1048575;
  localparam logic signed [TrkW-1:0] TRK_MIN = -21'sd1048576;

  typedef struct packed {
    logic signed [ExtW-1:0] lo_a;
    logic signed [ExtW-1:0] hi_a;
    logic signed [ExtW-1:0] lo_c;
    logic signed [ExtW-1:0] hi_c;
  } bounds_t;

endpackage

// ----- design/oriented_box_fit.sv -----
// ----------------------------------------------------------------------------
// oriented_box_fit - oriented bounding box of an obstacle's points
// Rotates points into the heading frame, tracks min and max, and on the last
// point emits the world-frame center and the clamped width and length.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------
//  point    | point_x, point_y, last_point              | point_valid/point_stall
//  box      | box_cx, box_cy, box_width, box_length     | box_valid/box_stall
//  config   | cfg_write, cfg_index, cfg_data            | write on cfg_write
//
//  one point transfer per cycle unless stalled; a box passes fin, ext, sx and cx_sum
//  the pipeline is eight register stages; each tracker loop closes through its own register
//  reset clears the valid bits, presets the trackers to their extremes and the registers to defaults
//  a stalled result freezes the whole pipeline and raises point_stall
//
module oriented_box_fit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [obf_pkg::CfgIdxW-1:0]            cfg_index,
  input  logic [obf_pkg::CfgDataW-1:0]           cfg_data,
  input  logic                                   point_valid,
  output logic                                   point_stall,
  input  logic signed [obf_pkg::PointW-1:0]      point_x,
  input  logic signed [obf_pkg::PointW-1:0]      point_y,
  input  logic                                   last_point,
  output logic                                   box_valid,
  input  logic                                   box_stall,
  output logic signed [obf_pkg::OutW-1:0]        box_cx,
  output logic signed [obf_pkg::OutW-1:0]        box_cy,
  output logic        [obf_pkg::OutW-1:0]        box_width,
  output logic        [obf_pkg::OutW-1:0]        box_length
);

  localparam int RotW = 38;
  localparam int BckW = 42;

  logic signed [obf_pkg::CoefW-1:0] heading_cos;
  logic signed [obf_pkg::CoefW-1:0] heading_sin;
  logic        [obf_pkg::MinW-1:0]  min_width;
  logic        [obf_pkg::MinW-1:0]  min_length;

  logic adv;

  // input register
  logic                              v0, last0;
  logic signed [obf_pkg::PointW-1:0] px0, py0;
  // rotated sums
  logic                              v1, last1;
  logic signed [RotW-1:0]            along_sum, across_sum;
  // rounded rotated point
  logic                              v2, last2;
  logic signed [obf_pkg::TrkW-1:0]   along, across;
  logic signed [RotW-1:0]            along_rnd, across_rnd;
  logic signed [obf_pkg::TrkW-1:0]   along_next, across_next;
  // trackers
  logic signed [obf_pkg::TrkW-1:0]   min_along, max_along, min_across, max_across;
  logic signed [obf_pkg::TrkW-1:0]   min_along_next, max_along_next;
  logic signed [obf_pkg::TrkW-1:0]   min_across_next, max_across_next;
  logic                              v3;
  obf_pkg::bounds_t                  fin;
  // extended bounds
  logic                              v4;
  obf_pkg::bounds_t                  ext, ext_next;
  logic signed [obf_pkg::ExtW-1:0]   mw_s, ml_s;
  // doubled center and extents
  logic                              v5;
  logic signed [obf_pkg::SumW-1:0]   sx, sy, wd_next, ln_next;
  logic        [obf_pkg::OutW-1:0]   wd, ln, wd_sat, ln_sat;
  // back rotation sums
  logic                              v6;
  logic signed [BckW-1:0]            cx_sum, cy_sum, cx_rnd, cy_rnd;
  logic        [obf_pkg::OutW-1:0]   wd6, ln6;
  logic signed [obf_pkg::OutW-1:0]   cx_next, cy_next;

  assign adv         = !(box_valid && box_stall);
  assign point_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_cos <= 16'sd32767;
      heading_sin <= '0;
      min_width   <= '0;
      min_length  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        obf_pkg::REG_HEADING_COS: heading_cos <= cfg_data;
        obf_pkg::REG_HEADING_SIN: heading_sin <= cfg_data;
        obf_pkg::REG_MIN_WIDTH:   min_width   <= cfg_data[obf_pkg::MinW-1:0];
        obf_pkg::REG_MIN_LENGTH:  min_length  <= cfg_data[obf_pkg::MinW-1:0];
        default: ;
      endcase
    end
  end

  // round half up and saturate the rotated point
  always_comb begin
    along_rnd  = (along_sum + RotW'(16384)) >>> 15;
    across_rnd = (across_sum + RotW'(16384)) >>> 15;
    if (along_rnd > RotW'(signed'(obf_pkg::TRK_MAX)))
      along_next = obf_pkg::TRK_MAX;
    else if (along_rnd < RotW'(signed'(obf_pkg::TRK_MIN)))
      along_next = obf_pkg::TRK_MIN;
    else
      along_next = along_rnd[obf_pkg::TrkW-1:0];
    if (across_rnd > RotW'(signed'(obf_pkg::TRK_MAX)))
      across_next = obf_pkg::TRK_MAX;
    else if (across_rnd < RotW'(signed'(obf_pkg::TRK_MIN)))
      across_next = obf_pkg::TRK_MIN;
    else
      across_next = across_rnd[obf_pkg::TrkW-1:0];
  end

  // tracker update
  always_comb begin
    min_along_next  = (along  < min_along)  ? along  : min_along;
    max_along_next  = (along  > max_along)  ? along  : max_along;
    min_across_next = (across < min_across) ? across : min_across;
    max_across_next = (across > max_across) ? across : max_across;
  end

  // extension of a box that lies on one side of an axis
  always_comb begin
    mw_s     = signed'({{(obf_pkg::ExtW-obf_pkg::MinW){1'b0}}, min_width});
    ml_s     = signed'({{(obf_pkg::ExtW-obf_pkg::MinW){1'b0}}, min_length});
    ext_next = fin;
    if (fin.hi_c < 0) begin
      if (fin.hi_c - mw_s < fin.lo_c) ext_next.lo_c = fin.hi_c - mw_s;
    end else if (fin.lo_c > 0) begin
      if (fin.lo_c + mw_s > fin.hi_c) ext_next.hi_c = fin.lo_c + mw_s;
    end
    if (fin.hi_a < 0) begin
      if (fin.hi_a - ml_s < fin.lo_a) ext_next.lo_a = fin.hi_a - ml_s;
    end else if (fin.lo_a > 0) begin
      if (fin.lo_a + ml_s > fin.hi_a) ext_next.hi_a = fin.lo_a + ml_s;
    end
  end

  // extents, raised to the minimum and saturated
  always_comb begin
    wd_next = obf_pkg::SumW'(ext.hi_c) - obf_pkg::SumW'(ext.lo_c);
    ln_next = obf_pkg::SumW'(ext.hi_a) - obf_pkg::SumW'(ext.lo_a);
    if (wd_next < obf_pkg::SumW'(mw_s)) wd_next = obf_pkg::SumW'(mw_s);
    if (ln_next < obf_pkg::SumW'(ml_s)) ln_next = obf_pkg::SumW'(ml_s);
    if (wd_next > obf_pkg::SumW'(1048575)) wd_sat = '1;
    else wd_sat = wd_next[obf_pkg::OutW-1:0];
    if (ln_next > obf_pkg::SumW'(1048575)) ln_sat = '1;
    else ln_sat = ln_next[obf_pkg::OutW-1:0];
  end

  // round half up and saturate the world-frame center
  always_comb begin
    cx_rnd = (cx_sum + BckW'(32768)) >>> 16;
    cy_rnd = (cy_sum + BckW'(32768)) >>> 16;
    if (cx_rnd > BckW'(524287))       cx_next = 20'sd524287;
    else if (cx_rnd < -BckW'(524288)) cx_next = -20'sd524288;
    else                              cx_next = cx_rnd[obf_pkg::OutW-1:0];
    if (cy_rnd > BckW'(524287))       cy_next = 20'sd524287;
    else if (cy_rnd < -BckW'(524288)) cy_next = -20'sd524288;
    else                              cy_next = cy_rnd[obf_pkg::OutW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      box_valid  <= 1'b0;
      min_along  <= obf_pkg::TRK_MAX;
      max_along  <= obf_pkg::TRK_MIN;
      min_across <= obf_pkg::TRK_MAX;
      max_across <= obf_pkg::TRK_MIN;
    end else if (adv) begin
      v0 <= point_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2 && last2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      box_valid <= v6;
      if (v2) begin
        if (last2) begin
          min_along  <= obf_pkg::TRK_MAX;
          max_along  <= obf_pkg::TRK_MIN;
          min_across <= obf_pkg::TRK_MAX;
          max_across <= obf_pkg::TRK_MIN;
        end else begin
          min_along  <= min_along_next;
          max_along  <= max_along_next;
          min_across <= min_across_next;
          max_across <= max_across_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px0   <= point_x;
      py0   <= point_y;
      last0 <= last_point;

      along_sum  <= RotW'(heading_cos * px0) + RotW'(heading_sin * py0);
      across_sum <= RotW'(heading_cos * py0) - RotW'(heading_sin * px0);
      last1      <= last0;

      along  <= along_next;
      across <= across_next;
      last2  <= last1;

      fin.lo_a <= obf_pkg::ExtW'(min_along_next);
      fin.hi_a <= obf_pkg::ExtW'(max_along_next);
      fin.lo_c <= obf_pkg::ExtW'(min_across_next);
      fin.hi_c <= obf_pkg::ExtW'(max_across_next);

      ext <= ext_next;

      sx <= obf_pkg::SumW'(ext.lo_a) + obf_pkg::SumW'(ext.hi_a);
      sy <= obf_pkg::SumW'(ext.lo_c) + obf_pkg::SumW'(ext.hi_c);
      wd <= wd_sat;
      ln <= ln_sat;

      cx_sum <= BckW'(heading_cos * sx) - BckW'(heading_sin * sy);
      cy_sum <= BckW'(heading_sin * sx) + BckW'(heading_cos * sy);
      wd6    <= wd;
      ln6    <= ln;

      box_cx     <= cx_next;
      box_cy     <= cy_next;
      box_width  <= wd6;
      box_length <= ln6;
    end
  end

endmodule
